[rtl/pgbc_pkg.sv]
// shared constants, payload types and control types for the palette gray converter
package pgbc_pkg;

  localparam int IMAGE_WIDTH     = 480;
  localparam int IMAGE_HEIGHT    = 800;
  localparam int PALETTE_DEPTH   = 16;

  localparam int ROW_BYTES       = (IMAGE_WIDTH + 7) / 8;
  localparam int ROW_INPUT_BYTES = (IMAGE_WIDTH + 1) / 2;
  localparam int COL_W           = $clog2(ROW_INPUT_BYTES);
  localparam int ROW_W           = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
  localparam int ENTRY_W         = 4;
  localparam int LUMA_W          = 15;
  localparam int CNT_W           = 5;
  localparam int PADDR_W         = 16;

  localparam int LUMA_R          = 30;
  localparam int LUMA_G          = 59;
  localparam int LUMA_B          = 11;

  localparam logic [CNT_W-1:0] COUNT_MIN   = CNT_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(PALETTE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RANK  = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;

  localparam logic KIND_RANK  = 1'b0;
  localparam logic KIND_PLANE = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_BAD   = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ENTRY_W-1:0] entry_index;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [7:0]         pixel_pair;
  } pgbc_in_t;

  typedef struct packed {
    logic               kind;
    logic               status;
    logic [ENTRY_W-1:0] gray0_index;
    logic [ENTRY_W-1:0] gray1_index;
    logic [ENTRY_W-1:0] gray2_index;
    logic [ENTRY_W-1:0] gray3_index;
    logic [PADDR_W-1:0] plane_address;
    logic [7:0]         low_plane_byte;
    logic [7:0]         high_plane_byte;
    logic               frame_done;
  } pgbc_out_t;

  typedef enum logic {WS_COPY, WS_CUR} pgbc_wsel_t;

  typedef struct packed {
    logic               luma_we;
    logic [ENTRY_W-1:0] luma_raddr;
    logic [ENTRY_W-1:0] rank_raddr;
    logic               rank_we;
    logic [ENTRY_W-1:0] rank_waddr;
    pgbc_wsel_t         wsel;
    logic               cur_load;
    logic               cmp_en;
    logic               map_we;
    logic [1:0]         map_slot;
    logic               pix_go;
    logic               rep_load;
    logic               rep_status;
    logic               clear_cnt;
  } pgbc_cmd_t;

  typedef struct packed {
    logic out_free;
  } pgbc_stat_t;

endpackage

[rtl/pgbc_ctrl.sv]
// sequencer: request handshake and the palette ranking walk
module pgbc_ctrl
  import pgbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pgbc_in_t         in_data,
  input  logic [CNT_W-1:0] color_count,
  input  pgbc_stat_t       stat,
  output pgbc_cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_COPY_RD, ST_COPY_WR, ST_OUTER_RD, ST_OUTER_LD, ST_INNER_RD,
    ST_INNER_CMP, ST_STORE, ST_MAP_RD, ST_MAP_WR, ST_REPORT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;
  logic [1:0]       sel_r;

  logic             accept;
  logic             cnt_ok;
  logic [CNT_W-1:0] map_addr;

  assign in_ready = (state_r == ST_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;
  assign cnt_ok   = (color_count >= COUNT_MIN) && (color_count <= COUNT_MAX);

  always_comb begin
    case (sel_r)
      2'd0:    map_addr = '0;
      2'd1:    map_addr = CNT_W'(1);
      2'd2:    map_addr = n_r - CNT_W'(2);
      default: map_addr = n_r - CNT_W'(1);
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.wsel = WS_CUR;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_LOAD:  cmd.luma_we = 1'b1;
            CMD_RANK: begin
              // bad count reports the current map right away
              if (!cnt_ok) begin
                cmd.rep_load   = 1'b1;
                cmd.rep_status = STAT_BAD;
              end
            end
            CMD_PIXEL: cmd.pix_go = 1'b1;
            default:   cmd.pix_go = 1'b0;
          endcase
        end
      end
      ST_COPY_RD:  cmd.luma_raddr = i_r[ENTRY_W-1:0];
      ST_COPY_WR: begin
        cmd.rank_we    = 1'b1;
        cmd.rank_waddr = i_r[ENTRY_W-1:0];
        cmd.wsel       = WS_COPY;
      end
      ST_OUTER_RD: cmd.rank_raddr = i_r[ENTRY_W-1:0];
      ST_OUTER_LD: cmd.cur_load   = 1'b1;
      ST_INNER_RD: cmd.rank_raddr = j_r[ENTRY_W-1:0];
      ST_INNER_CMP: begin
        cmd.cmp_en     = 1'b1;
        cmd.rank_waddr = j_r[ENTRY_W-1:0];
      end
      ST_STORE: begin
        cmd.rank_we    = 1'b1;
        cmd.rank_waddr = i_r[ENTRY_W-1:0];
      end
      ST_MAP_RD: cmd.rank_raddr = map_addr[ENTRY_W-1:0];
      ST_MAP_WR: begin
        cmd.map_we   = 1'b1;
        cmd.map_slot = ~sel_r;
      end
      ST_REPORT: begin
        if (stat.out_free) begin
          cmd.rep_load   = 1'b1;
          cmd.rep_status = STAT_OK;
          cmd.clear_cnt  = 1'b1;
        end
      end
      default: cmd.rep_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      sel_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && in_data.cmd == CMD_RANK && cnt_ok) begin
            n_r     <= color_count;
            i_r     <= '0;
            state_r <= ST_COPY_RD;
          end
        end
        ST_COPY_RD: state_r <= ST_COPY_WR;
        ST_COPY_WR: begin
          if (i_r == n_r - CNT_W'(1)) begin
            i_r     <= '0;
            state_r <= ST_OUTER_RD;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= ST_COPY_RD;
          end
        end
        ST_OUTER_RD: state_r <= ST_OUTER_LD;
        ST_OUTER_LD: begin
          j_r     <= i_r + CNT_W'(1);
          state_r <= ST_INNER_RD;
        end
        ST_INNER_RD: state_r <= ST_INNER_CMP;
        ST_INNER_CMP: begin
          if (j_r == n_r - CNT_W'(1)) begin
            state_r <= ST_STORE;
          end else begin
            j_r     <= j_r + CNT_W'(1);
            state_r <= ST_INNER_RD;
          end
        end
        ST_STORE: begin
          if (i_r == n_r - CNT_W'(2)) begin
            sel_r   <= '0;
            state_r <= ST_MAP_RD;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= ST_OUTER_RD;
          end
        end
        ST_MAP_RD: state_r <= ST_MAP_WR;
        ST_MAP_WR: begin
          if (sel_r == 2'd3) begin
            state_r <= ST_REPORT;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= ST_MAP_RD;
          end
        end
        ST_REPORT: begin
          if (stat.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_rank_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_RANK && cnt_ok) |=> state_r == ST_COPY_RD)
    else $error("valid rank request did not start the walk");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (n_r >= COUNT_MIN && n_r <= COUNT_MAX))
    else $error("walk running with an out of range count");

  a_inner_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INNER_CMP) |-> (j_r > i_r && j_r < n_r))
    else $error("inner index outside i < j < n");

endmodule

[rtl/pgbc_dp.sv]
// datapath: luma and rank memories, gray map, plane accumulators, result register
module pgbc_dp
  import pgbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pgbc_in_t   in_data,
  input  pgbc_cmd_t  cmd,
  output pgbc_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output pgbc_out_t  out_data
);

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [LUMA_W-1:0]  luma;
  } rank_t;

  localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(ROW_INPUT_BYTES - 1);
  localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [PADDR_W-1:0] BASE_TOP   =
    PADDR_W'(((IMAGE_HEIGHT - 1) * ROW_BYTES) % 65536);
  localparam logic [PADDR_W-1:0] ROW_STEP   = PADDR_W'(ROW_BYTES);
  localparam logic               ODD_WIDTH  = (IMAGE_WIDTH % 2) == 1;
  localparam logic [7:0]         MSB_MASK   = 8'h80;

  logic [LUMA_W-1:0]  luma_mem [PALETTE_DEPTH];
  rank_t              rank_mem [PALETTE_DEPTH];
  logic [LUMA_W-1:0]  luma_rdata_r;
  rank_t              rank_rdata_r;
  rank_t              cur_r;
  logic [ENTRY_W-1:0] map_r [4];

  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [PADDR_W-1:0] base_r;
  logic [7:0]         lo_acc_r;
  logic [7:0]         hi_acc_r;
  logic               out_valid_r;
  pgbc_out_t          out_r;

  logic [LUMA_W-1:0]  luma_in;
  logic               gt;
  logic               rank_wen;
  rank_t              rank_wdata;
  logic               row_end;
  logic               emit;
  logic               lo_ok;
  logic [1:0]         g_hi;
  logic [1:0]         g_lo;
  logic [7:0]         mask_hi;
  logic [7:0]         mask_lo;
  logic [7:0]         lo_nxt;
  logic [7:0]         hi_nxt;

  // lowest matching slot wins, no match gives gray 0
  function automatic logic [1:0] lookup_gray(input logic [ENTRY_W-1:0] idx,
                                             input logic [4*ENTRY_W-1:0] map);
    logic [1:0] g;
    g = 2'd0;
    for (int s = 3; s >= 0; s--) begin
      if (map[s*ENTRY_W +: ENTRY_W] == idx) g = 2'(s);
    end
    return g;
  endfunction

  assign luma_in = LUMA_W'(16'(in_data.red)   * 16'(LUMA_R)
                         + 16'(in_data.green) * 16'(LUMA_G)
                         + 16'(in_data.blue)  * 16'(LUMA_B));

  assign gt         = cur_r.luma > rank_rdata_r.luma;
  assign rank_wen   = cmd.rank_we || (cmd.cmp_en && gt);
  assign rank_wdata = (cmd.wsel == WS_COPY) ? rank_t'{cmd.rank_waddr, luma_rdata_r} : cur_r;

  always_ff @(posedge clk) begin
    if (cmd.luma_we) begin
      luma_mem[in_data.entry_index] <= luma_in;
    end
    luma_rdata_r <= luma_mem[cmd.luma_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_wen) begin
      rank_mem[cmd.rank_waddr] <= rank_wdata;
    end
    rank_rdata_r <= rank_mem[cmd.rank_raddr];
  end

  // running candidate for slot i of the exchange sort
  always_ff @(posedge clk) begin
    if (cmd.cur_load || (cmd.cmp_en && gt)) begin
      cur_r <= rank_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 4; s++) map_r[s] <= '0;
    end else if (cmd.map_we) begin
      map_r[cmd.map_slot] <= rank_rdata_r.idx;
    end
  end

  assign row_end = (col_r == COL_LAST);
  assign emit    = (&col_r[1:0]) || row_end;
  assign lo_ok   = !(ODD_WIDTH && row_end);
  assign g_hi    = lookup_gray(in_data.pixel_pair[7:4], {map_r[3], map_r[2], map_r[1], map_r[0]});
  assign g_lo    = lookup_gray(in_data.pixel_pair[3:0], {map_r[3], map_r[2], map_r[1], map_r[0]});
  assign mask_hi = MSB_MASK >> {col_r[1:0], 1'b0};
  assign mask_lo = lo_ok ? (MSB_MASK >> {col_r[1:0], 1'b1}) : 8'h00;
  assign lo_nxt  = lo_acc_r | (g_hi[0] ? mask_hi : 8'h00) | (g_lo[0] ? mask_lo : 8'h00);
  assign hi_nxt  = hi_acc_r | (g_hi[1] ? mask_hi : 8'h00) | (g_lo[1] ? mask_lo : 8'h00);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_cnt) begin
      col_r    <= '0;
      row_r    <= '0;
      base_r   <= BASE_TOP;
      lo_acc_r <= '0;
      hi_acc_r <= '0;
    end else if (cmd.pix_go) begin
      if (emit) begin
        lo_acc_r <= '0;
        hi_acc_r <= '0;
      end else begin
        lo_acc_r <= lo_nxt;
        hi_acc_r <= hi_nxt;
      end
      if (row_end) begin
        col_r <= '0;
        if (row_r == ROW_LAST) begin
          row_r  <= '0;
          base_r <= BASE_TOP;
        end else begin
          row_r  <= row_r + ROW_W'(1);
          base_r <= base_r - ROW_STEP;
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rep_load || (cmd.pix_go && emit)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_load) begin
      out_r                 <= '0;
      out_r.kind            <= KIND_RANK;
      out_r.status          <= cmd.rep_status;
      out_r.gray0_index     <= map_r[0];
      out_r.gray1_index     <= map_r[1];
      out_r.gray2_index     <= map_r[2];
      out_r.gray3_index     <= map_r[3];
    end else if (cmd.pix_go && emit) begin
      out_r                 <= '0;
      out_r.kind            <= KIND_PLANE;
      out_r.plane_address   <= base_r + PADDR_W'(col_r >> 2);
      out_r.low_plane_byte  <= lo_nxt;
      out_r.high_plane_byte <= hi_nxt;
      out_r.frame_done      <= row_end && (row_r == ROW_LAST);
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rep_load && cmd.pix_go))
    else $error("report and pixel request loaded together");

  a_frame_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_done) |-> out_r.kind == KIND_PLANE)
    else $error("frame end flagged on a rank report");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.rep_load || cmd.pix_go))
    else $error("result register loaded while the held result is stalled");

endmodule

[rtl/palette_gray_bitplane_converter.sv]
// top level: configuration register, sequencer and datapath
// load and pixel requests: one per cycle while the output register is free; a plane pair is
// held in the output register in the cycle after the fourth (or row end) byte is accepted
// rank request with count n: the luma copy, then the exchange sort walking the rank memory
// with a read and a compare per pair, then the gray map; a bad count reports in the next cycle
// reset (rst_n low, synchronous): idle, gray map and position counters zero, color_count 16;
// palette memories keep their contents and are undefined until written
module palette_gray_bitplane_converter
  import pgbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pgbc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pgbc_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] color_count_r;
  pgbc_cmd_t        cmd;
  pgbc_stat_t       stat;

  // only word 0 holds a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COUNT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      color_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, color_count_r};

  pgbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .color_count (color_count_r),
    .stat        (stat),
    .cmd         (cmd)
  );

  pgbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[bench/palette_gray_bitplane_converter_tb.sv]
`timescale 1ns / 1ps
// testbench for the palette gray bit-plane converter: directed and random requests, self-checking
module palette_gray_bitplane_converter_tb
  import pgbc_pkg::*;
();

  localparam logic [1:0] CMD_NOP        = 2'd3;
  localparam int         REG_COLOR_COUNT = 0;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         TAIL_CYCLES     = 20;
  localparam int         MAX_REPORTS     = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pgbc_in_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pgbc_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  palette_gray_bitplane_converter dut (.*);

  // predicted block state
  logic [LUMA_W-1:0]  pal_luma [16];
  logic [ENTRY_W-1:0] gray_of [4] = '{default: '0};
  int unsigned        col_byte = 0;
  int unsigned        row_src = 0;
  logic [7:0]         acc_lo = '0;
  logic [7:0]         acc_hi = '0;
  int unsigned        active_colors = COUNT_RESET;

  pgbc_out_t   pending_reports [$];
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned rank_reports = 0;
  int unsigned frames_done = 0;
  bit          idle_on = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [1:0] gray_level(logic [ENTRY_W-1:0] idx);
    // lowest matching gray wins, unmapped index is gray 0
    for (int g = 0; g < 4; g++)
      if (gray_of[g] == idx) return 2'(g);
    return 2'd0;
  endfunction

  // updates the predicted state and returns 1 when the request yields a result
  function automatic bit convert_request(pgbc_in_t req, output pgbc_out_t res);
    logic [ENTRY_W-1:0] order [16];
    logic [ENTRY_W-1:0] t;
    logic [1:0]         g;
    logic [7:0]         mask;
    int unsigned        x;
    bit                 row_end;
    res = '0;
    case (req.cmd)
      CMD_LOAD: begin
        pal_luma[req.entry_index] = LUMA_W'(int'(req.red) * LUMA_R + int'(req.green) * LUMA_G
                                            + int'(req.blue) * LUMA_B);
        return 1'b0;
      end
      CMD_RANK: begin
        res.kind = KIND_RANK;
        if (active_colors < COUNT_MIN || active_colors > COUNT_MAX) begin
          res.status = STAT_BAD;
        end else begin
          for (int i = 0; i < active_colors; i++) order[i] = ENTRY_W'(i);
          for (int i = 0; i + 1 < active_colors; i++)
            for (int j = i + 1; j < active_colors; j++)
              if (pal_luma[order[i]] > pal_luma[order[j]]) begin
                t = order[i];
                order[i] = order[j];
                order[j] = t;
              end
          gray_of[3] = order[0];
          gray_of[2] = order[1];
          gray_of[1] = order[active_colors - 2];
          gray_of[0] = order[active_colors - 1];
          col_byte = 0;
          row_src = 0;
          acc_lo = '0;
          acc_hi = '0;
          res.status = STAT_OK;
        end
        res.gray0_index = gray_of[0];
        res.gray1_index = gray_of[1];
        res.gray2_index = gray_of[2];
        res.gray3_index = gray_of[3];
        return 1'b1;
      end
      CMD_PIXEL: begin
        x = col_byte * 2;
        row_end = (col_byte + 1 >= ROW_INPUT_BYTES);
        for (int p = 0; p < 2; p++)
          if (x + p < IMAGE_WIDTH) begin
            g = gray_level(p == 0 ? req.pixel_pair[7:4] : req.pixel_pair[3:0]);
            mask = 8'h80 >> ((x + p) % 8);
            if (g[0]) acc_lo |= mask;
            if (g[1]) acc_hi |= mask;
          end
        if (!(col_byte % 4 == 3 || row_end)) begin
          col_byte++;
          return 1'b0;
        end
        res.kind = KIND_PLANE;
        res.plane_address = PADDR_W'((IMAGE_HEIGHT - 1 - row_src) * ROW_BYTES + x / 8);
        res.low_plane_byte = acc_lo;
        res.high_plane_byte = acc_hi;
        acc_lo = '0;
        acc_hi = '0;
        if (row_end) begin
          col_byte = 0;
          if (row_src + 1 >= IMAGE_HEIGHT) begin
            row_src = 0;
            res.frame_done = 1'b1;
          end else begin
            row_src++;
          end
        end else begin
          col_byte++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic pgbc_in_t random_request(logic [1:0] cmd);
    logic [63:0] noise;
    pgbc_in_t    req;
    noise = {$urandom, $urandom};
    req = noise[$bits(pgbc_in_t)-1:0];
    req.cmd = cmd;
    return req;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pgbc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.kind == KIND_RANK) rank_reports++;
      if (out_data.frame_done) frames_done++;
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = pending_reports.pop_front();
        compare_field("kind", want.kind, out_data.kind);
        compare_field("status", want.status, out_data.status);
        compare_field("gray0_index", want.gray0_index, out_data.gray0_index);
        compare_field("gray1_index", want.gray1_index, out_data.gray1_index);
        compare_field("gray2_index", want.gray2_index, out_data.gray2_index);
        compare_field("gray3_index", want.gray3_index, out_data.gray3_index);
        compare_field("plane_address", want.plane_address, out_data.plane_address);
        compare_field("low_plane_byte", want.low_plane_byte, out_data.low_plane_byte);
        compare_field("high_plane_byte", want.high_plane_byte, out_data.high_plane_byte);
        compare_field("frame_done", want.frame_done, out_data.frame_done);
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  always @(posedge clk) begin
    if (holds_granted != holds_asked) begin
      holds_granted = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(pgbc_in_t req);
    pgbc_out_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (convert_request(req, res)) pending_reports.push_back(res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color_count(int unsigned value);
    logic [31:0] readback;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_COLOR_COUNT);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    active_colors = value & 31;
    // read back through the same port
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    compare_field("color_count readback", 32'(active_colors), readback);
  endtask

  task automatic send_rank();
    send_request(random_request(CMD_RANK));
  endtask

  task automatic send_pixels(logic [7:0] pair);
    pgbc_in_t req;
    req = random_request(CMD_PIXEL);
    req.pixel_pair = pair;
    send_request(req);
  endtask

  // map is all zero after reset: index 0 sits in every slot and gray 0 wins
  task automatic test_reset_map();
    send_pixels(8'h0F);
    send_pixels(8'hF0);
    send_request(random_request(CMD_NOP));
    send_pixels(8'h00);
    send_pixels(8'hFF);
    drain();
  endtask

  task automatic test_palette_load();
    pgbc_in_t req;
    for (int e = 0; e < 16; e++) begin
      req = random_request(CMD_LOAD);
      req.entry_index = ENTRY_W'(e);
      case (e)
        0:       {req.blue, req.green, req.red} = {8'hFF, 8'hFF, 8'hFF};
        1:       {req.blue, req.green, req.red} = '0;
        2, 3, 5: {req.blue, req.green, req.red} = {8'h40, 8'h80, 8'h20};  // equal luma
        4:       {req.blue, req.green, req.red} = {8'hFF, 8'h00, 8'h00};
        6:       {req.blue, req.green, req.red} = {8'h00, 8'h00, 8'hFF};
        7:       {req.blue, req.green, req.red} = {8'h00, 8'hFF, 8'h00};
        default: ;
      endcase
      send_request(req);
    end
    drain();
  endtask

  task automatic test_rank_counts();
    send_rank();                       // reset count of 16
    write_color_count(4);
    send_rank();
    // indices past the ranked four stay unmapped
    send_pixels(8'h01);
    send_pixels(8'h23);
    send_pixels(8'h45);
    send_pixels(8'hEF);
    write_color_count(3);
    send_rank();
    write_color_count(17);
    send_rank();
    write_color_count(16);
    send_rank();
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned count_choices [6] = '{0, 3, 4, 16, 17, 31};
    idle_on = 1'b1;
    for (int phase = 0; phase < 7; phase++) begin
      if ($urandom_range(0, 1) == 0)
        write_color_count(count_choices[$urandom_range(0, 5)]);
      else
        write_color_count($urandom_range(4, 16));
      send_rank();
      for (int k = 0; k < 100; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      send_request(random_request(CMD_PIXEL));
        else if (pick < 90) send_request(random_request(CMD_LOAD));
        else if (pick < 95) send_request(random_request(CMD_RANK));
        else                send_request(random_request(CMD_NOP));
      end
    end
    drain();
  endtask

  // receiver holds off while pixel requests keep coming, so the input stalls
  task automatic test_backpressure();
    write_color_count($urandom_range(4, 16));
    send_rank();
    holds_asked++;
    for (int k = 0; k < 120; k++) begin
      if (k == 60) send_rank();
      send_request(random_request(CMD_PIXEL));
    end
    drain();
  endtask

  // one whole row with no idling, through the row end and into the next row
  task automatic test_full_row();
    idle_on = 1'b0;
    write_color_count($urandom_range(4, 16));
    send_rank();
    for (int k = 0; k < ROW_INPUT_BYTES; k++)
      send_request(random_request(CMD_PIXEL));
    send_pixels(8'hA5);
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_map();
    test_palette_load();
    test_rank_counts();
    test_random_traffic();
    test_backpressure();
    test_full_row();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d requests and %0d results, %0d of them rank reports",
             requests_sent, results_seen, rank_reports);
    $display("frames completed: %0d, field mismatches: %0d", frames_done, fail_count);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
